// ----- rtl/mandelbrot_escape_time_pixel_core_assert.svh -----
// Assertion macros shared by the escape-time core modules.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MBROT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape-time core: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MBROT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape-time core: assertion failed");

`endif

// ----- rtl/mbrot_pkg.sv -----
// Shared types, constants and helper functions of the escape-time core.
package mbrot_pkg;

    localparam int PIX_W      = 19;
    localparam int COUNT_W    = 12;
    localparam int COORD_W    = 64;
    localparam int STEP_W     = 63;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int FRAC_W     = 60;
    localparam int ESCAPE_BIT = 2 * FRAC_W + 2;   // 4.0 in Q8.120
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_CNT_W  = $clog2(PIX_W + 1);

    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_RE       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_IM       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_RE         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_IM         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ITERATION_LIMIT = 3'd4;

    localparam logic [COORD_W-1:0] ORIGIN_RE_RESET = 64'hE000_0000_0000_0000; // -2.0
    localparam logic [COORD_W-1:0] ORIGIN_IM_RESET = 64'hE800_0000_0000_0000; // -1.5
    localparam logic [STEP_W-1:0]  STEP_RE_RESET   = 63'd5764607523034235;
    localparam logic [STEP_W-1:0]  STEP_IM_RESET   = 63'd5764607523034235;
    localparam logic [COUNT_W-1:0] LIMIT_RESET     = 12'd768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_CRE,
        ST_MUL_CIM,
        ST_ITER,
        ST_MUL_RR,
        ST_MUL_II,
        ST_CHECK,
        ST_MUL_RI,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

    // magnitude of a two's complement word; the most negative value maps to 2^63
    function automatic logic [COORD_W-1:0] mag64(input logic [COORD_W-1:0] value);
        logic [COORD_W-1:0] result;
        result = value[COORD_W-1] ? (~value + 1'b1) : value;
        return result;
    endfunction

    // base + delta (both signed), clamped to the Q4.60 range
    function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] base,
                                                   input logic [PROD_W-1:0]  delta);
        logic [PROD_W:0]    total;
        logic [COORD_W-1:0] result;
        total = {delta[PROD_W-1], delta}
              + {{(PROD_W - COORD_W + 1){base[COORD_W-1]}}, base};
        priority if (&total[PROD_W:COORD_W-1] || !(|total[PROD_W:COORD_W-1]))
            result = total[COORD_W-1:0];
        else if (total[PROD_W])
            result = {1'b1, {(COORD_W - 1){1'b0}}};
        else
            result = {1'b0, {(COORD_W - 1){1'b1}}};
        return result;
    endfunction

endpackage

// ----- rtl/mbrot_mul.sv -----
// Shared 64x64 unsigned multiplier built from one 32x32 multiplier over four passes.
`include "mandelbrot_escape_time_pixel_core_assert.svh"

module mbrot_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  mbrot_pkg::mul_req_t req,
    output mbrot_pkg::mul_rsp_t rsp
);
    import mbrot_pkg::*;

    localparam int HALF_W = COORD_W / 2;
    localparam logic [2:0] LAST_PASS = 3'd4;

    logic                busy_reg, busy_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                ppv_reg, ppv_next;
    logic                done_reg, done_next;
    logic [COORD_W-1:0]  a_reg, a_next;
    logic [COORD_W-1:0]  b_reg, b_next;
    logic [COORD_W-1:0]  pp_reg, pp_next;
    logic [1:0]          sh_reg, sh_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;

    logic [HALF_W-1:0]   a_half;
    logic [HALF_W-1:0]   b_half;
    logic [PROD_W-1:0]   pp_aligned;

    always_comb
    begin
        a_half = cnt_reg[1] ? a_reg[COORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_half = cnt_reg[0] ? b_reg[COORD_W-1:HALF_W] : b_reg[HALF_W-1:0];

        unique case (sh_reg)
            2'd0:    pp_aligned = {{COORD_W{1'b0}}, pp_reg};
            2'd1:    pp_aligned = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default: pp_aligned = {pp_reg, {COORD_W{1'b0}}};
        endcase

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        ppv_next  = ppv_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = ppv_reg ? acc_reg + pp_aligned : acc_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            ppv_next  = 1'b0;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (!cnt_reg[2])
            begin
                // partial product of this pass, added in the next cycle
                pp_next  = a_half * b_half;
                sh_next  = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                ppv_next = 1'b1;
            end
            else
            begin
                ppv_next = 1'b0;
            end
            if (cnt_reg == LAST_PASS)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            ppv_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            ppv_reg  <= ppv_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    `MBROT_ASSERT_IMP(a_done_not_busy, done_reg, !busy_reg)
    `MBROT_ASSERT_NXT(a_done_one_cycle, done_reg, !done_reg)
    `MBROT_ASSERT_IMP(a_pp_only_busy, ppv_reg, busy_reg)

endmodule

// ----- rtl/mbrot_div.sv -----
// Splits a pixel index into row and column by multiplying with the reciprocal of the width.
module mbrot_div #(
    parameter  int COLUMNS = 800,
    localparam int RW      = $clog2(COLUMNS),
    localparam int QW      = mbrot_pkg::PIX_W + 1 - RW
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mbrot_pkg::PIX_W-1:0] dividend,
    output logic                       done,
    output logic [QW-1:0]              quotient,
    output logic [RW-1:0]              remainder
);
    import mbrot_pkg::*;

    // floor(x * RECIP / 2^SHIFT) equals floor(x / COLUMNS) for every x below 2^PIX_W:
    // RECIP * COLUMNS overshoots 2^SHIFT by less than 2^RW
    localparam int SHIFT   = PIX_W + RW;
    localparam int RECIP_W = PIX_W + 2;
    localparam int MULT_W  = PIX_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(((64'd1 << SHIFT) + 64'(COLUMNS)
                                                      - 64'd1) / 64'(COLUMNS));
    localparam logic [PIX_W-1:0]   COLS_K = PIX_W'(COLUMNS);

    logic                 stage1_reg, stage1_next;
    logic                 stage2_reg, stage2_next;
    logic                 done_reg, done_next;
    logic [PIX_W-1:0]     dividend_reg, dividend_next;
    logic [MULT_W-1:0]    prod_reg, prod_next;
    logic [QW-1:0]        quot_reg, quot_next;
    logic [RW-1:0]        rem_reg, rem_next;

    logic [QW-1:0]        quot_full;
    logic [PIX_W-1:0]     quot_times_cols;
    logic [PIX_W-1:0]     rem_full;

    always_comb
    begin
        quot_full       = prod_reg[SHIFT +: QW];
        quot_times_cols = PIX_W'(quot_full) * COLS_K;
        rem_full        = dividend_reg - quot_times_cols;

        stage1_next   = start;
        stage2_next   = stage1_reg;
        done_next     = stage2_reg;
        dividend_next = start ? dividend : dividend_reg;
        prod_next     = stage1_reg ? dividend_reg * RECIP : prod_reg;
        quot_next     = stage2_reg ? quot_full : quot_reg;
        rem_next      = stage2_reg ? rem_full[RW-1:0] : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= stage1_next;
            stage2_reg <= stage2_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        prod_reg     <= prod_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/mandelbrot_escape_time_pixel_core.sv -----
// Top level of the escape-time pixel core: sequencer, coordinate and z registers.
//
// Input channel: pixel_index with in_valid / in_stall. A request is taken when
// in_valid is high and in_stall low; in_stall is high while a pixel is in work.
// Output channel: escape_count and pixel_tag with out_valid / out_stall, held in
// an output register, so the next pixel is taken while a result waits.
// Configuration: cfg_wr_en, cfg_addr, cfg_wdata; write only while the core is idle.
// Addresses 0..4 are origin_re, origin_im, step_re, step_im, iteration_limit;
// others are ignored.
// A pixel is handled in order: the index is split into row and column, the point c
// is formed, then z = z*z + c is iterated until |z|^2 reaches 4.0 or the limit is
// reached. The core has a single 32x32 multiplier: each of the up to three 64x64
// products per iteration takes four passes plus an accumulate.
// Reset returns the configuration registers to their defaults and empties both channels.
// A stalled result holds in the output register; the core finishes the pixel in
// work and then waits until the output register is free.
`include "mandelbrot_escape_time_pixel_core_assert.svh"

module mandelbrot_escape_time_pixel_core #(
    parameter int IMAGE_COLUMNS = 800
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mbrot_pkg::PIX_W-1:0]      pixel_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mbrot_pkg::COUNT_W-1:0]    escape_count,
    output logic [mbrot_pkg::PIX_W-1:0]      pixel_tag,
    input  logic                             cfg_wr_en,
    input  logic [mbrot_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mbrot_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mbrot_pkg::*;

    localparam int COL_W = $clog2(IMAGE_COLUMNS);
    localparam int ROW_W = PIX_W + 1 - COL_W;

    state_t              state_reg, state_next;
    logic [PIX_W-1:0]    tag_reg, tag_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COORD_W-1:0]  cre_reg, cre_next;
    logic [COORD_W-1:0]  cim_reg, cim_next;
    logic [COORD_W-1:0]  zr_reg, zr_next;
    logic [COORD_W-1:0]  zi_reg, zi_next;
    logic [PROD_W-1:0]   r2_reg, r2_next;
    logic [PROD_W-1:0]   i2_reg, i2_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  escape_count_reg, escape_count_next;
    logic [PIX_W-1:0]    pixel_tag_reg, pixel_tag_next;

    logic [COORD_W-1:0]  origin_re_reg;
    logic [COORD_W-1:0]  origin_im_reg;
    logic [STEP_W-1:0]   step_re_reg;
    logic [STEP_W-1:0]   step_im_reg;
    logic [COUNT_W-1:0]  iteration_limit_reg;

    mul_req_t            mul_req;
    mul_rsp_t            mul_rsp;
    logic                div_start;
    logic                div_done;
    logic [ROW_W-1:0]    div_quotient;
    logic [COL_W-1:0]    div_remainder;

    logic [PROD_W-1:0]   sum_sq;
    logic                escaped;
    logic [PROD_W-1:0]   re_delta;
    logic [PROD_W-1:0]   im_delta;

    mbrot_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    mbrot_div #(
        .COLUMNS (IMAGE_COLUMNS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (tag_next),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // exact |z|^2 in Q8.120; escape once it reaches 4.0
    assign sum_sq  = r2_reg + i2_reg;
    assign escaped = |sum_sq[PROD_W-1:ESCAPE_BIT];

    // floor((r^2 - i^2) / 2^60) and floor(2*r*i / 2^60)
    assign re_delta = {{FRAC_W{r2_reg[PROD_W-1]}}, r2_reg[PROD_W-1:FRAC_W]};
    assign im_delta = {{(FRAC_W - 1){i2_reg[PROD_W-1]}}, i2_reg[PROD_W-1:FRAC_W-1]};

    always_comb
    begin
        state_next        = state_reg;
        tag_next          = tag_reg;
        row_next          = row_reg;
        cre_next          = cre_reg;
        cim_next          = cim_reg;
        zr_next           = zr_reg;
        zi_next           = zi_reg;
        r2_next           = r2_reg;
        i2_next           = i2_reg;
        n_next            = n_reg;
        escape_count_next = escape_count_reg;
        pixel_tag_next    = pixel_tag_reg;
        out_valid_next    = out_valid_reg && out_stall;
        mul_req           = '0;
        div_start         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tag_next   = pixel_index;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    row_next      = div_quotient;
                    mul_req.start = 1'b1;
                    mul_req.a     = COORD_W'(div_remainder);
                    mul_req.b     = {1'b0, step_re_reg};
                    state_next    = ST_MUL_CRE;
                end
            end
            ST_MUL_CRE:
            begin
                if (mul_rsp.done)
                begin
                    cre_next      = sat_add(origin_re_reg, mul_rsp.product);
                    mul_req.start = 1'b1;
                    mul_req.a     = COORD_W'(row_reg);
                    mul_req.b     = {1'b0, step_im_reg};
                    state_next    = ST_MUL_CIM;
                end
            end
            ST_MUL_CIM:
            begin
                if (mul_rsp.done)
                begin
                    cim_next   = sat_add(origin_im_reg, mul_rsp.product);
                    zr_next    = cre_reg;
                    zi_next    = cim_next;
                    n_next     = '0;
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                if (n_reg == iteration_limit_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mag64(zr_reg);
                    mul_req.b     = mag64(zr_reg);
                    state_next    = ST_MUL_RR;
                end
            end
            ST_MUL_RR:
            begin
                if (mul_rsp.done)
                begin
                    r2_next       = mul_rsp.product;
                    mul_req.start = 1'b1;
                    mul_req.a     = mag64(zi_reg);
                    mul_req.b     = mag64(zi_reg);
                    state_next    = ST_MUL_II;
                end
            end
            ST_MUL_II:
            begin
                if (mul_rsp.done)
                begin
                    i2_next    = mul_rsp.product;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (escaped)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    r2_next       = r2_reg - i2_reg;
                    mul_req.start = 1'b1;
                    mul_req.a     = mag64(zr_reg);
                    mul_req.b     = mag64(zi_reg);
                    state_next    = ST_MUL_RI;
                end
            end
            ST_MUL_RI:
            begin
                if (mul_rsp.done)
                begin
                    // restore the sign of r*i
                    i2_next    = (zr_reg[COORD_W-1] ^ zi_reg[COORD_W-1]) ?
                                 (~mul_rsp.product + 1'b1) : mul_rsp.product;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                zr_next    = sat_add(cre_reg, re_delta);
                zi_next    = sat_add(cim_reg, im_delta);
                n_next     = n_reg + 1'b1;
                state_next = ST_ITER;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    escape_count_next = n_reg;
                    pixel_tag_next    = tag_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg          <= tag_next;
        row_reg          <= row_next;
        cre_reg          <= cre_next;
        cim_reg          <= cim_next;
        zr_reg           <= zr_next;
        zi_reg           <= zi_next;
        r2_reg           <= r2_next;
        i2_reg           <= i2_next;
        n_reg            <= n_next;
        escape_count_reg <= escape_count_next;
        pixel_tag_reg    <= pixel_tag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg       <= ORIGIN_RE_RESET;
            origin_im_reg       <= ORIGIN_IM_RESET;
            step_re_reg         <= STEP_RE_RESET;
            step_im_reg         <= STEP_IM_RESET;
            iteration_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_ORIGIN_RE:       origin_re_reg       <= cfg_wdata;
                CFG_ORIGIN_IM:       origin_im_reg       <= cfg_wdata;
                CFG_STEP_RE:         step_re_reg         <= cfg_wdata[STEP_W-1:0];
                CFG_STEP_IM:         step_im_reg         <= cfg_wdata[STEP_W-1:0];
                CFG_ITERATION_LIMIT: iteration_limit_reg <= cfg_wdata[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign escape_count = escape_count_reg;
    assign pixel_tag    = pixel_tag_reg;

    `MBROT_ASSERT_IMP(a_mul_done_in_wait, mul_rsp.done,
        state_reg == ST_MUL_CRE || state_reg == ST_MUL_CIM || state_reg == ST_MUL_RR ||
        state_reg == ST_MUL_II || state_reg == ST_MUL_RI)
    `MBROT_ASSERT_IMP(a_div_done_in_div, div_done, state_reg == ST_DIV)
    `MBROT_ASSERT_IMP(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE)

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the Mandelbrot escape-time pixel core.
`timescale 1ns / 1ps

module tb;
    import mbrot_pkg::*;

    localparam int PIXEL_COLUMNS   = 800;
    localparam int PIXEL_LAST      = 479999;
    localparam int WATCHDOG_CYCLES = 300000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int RANDOM_PHASES   = 16;
    localparam int PHASE_ITEMS     = 48;
    localparam int REPORT_MAX      = 10;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W+1:0]  wide_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [PIX_W-1:0]   tag;
    } pixel_result_t;

    localparam coord_t           Q_ONE      = 64'sh1000_0000_0000_0000;
    localparam coord_t           Q_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam coord_t           Q_MIN      = 64'sh8000_0000_0000_0000;
    localparam logic [PIX_W-1:0] PIX_CENTER = 19'd240400;   // c = 0 in the default view
    localparam logic [PIX_W-1:0] PIX_ALL    = 19'h7FFFF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel_index = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COUNT_W-1:0]    escape_count;
    logic [PIX_W-1:0]      pixel_tag;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // register shadow
    coord_t             origin_re_q = ORIGIN_RE_RESET;
    coord_t             origin_im_q = ORIGIN_IM_RESET;
    logic [STEP_W-1:0]  step_re_q = STEP_RE_RESET;
    logic [STEP_W-1:0]  step_im_q = STEP_IM_RESET;
    logic [COUNT_W-1:0] iter_limit_q = LIMIT_RESET;

    pixel_result_t pending_results[$];
    int            error_count = 0;
    int            quiet_cycles = 0;
    int            stall_left = 0;
    bit            gaps_on = 1'b1;

    mandelbrot_escape_time_pixel_core #(
        .IMAGE_COLUMNS(PIXEL_COLUMNS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel_index(pixel_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .escape_count(escape_count),
        .pixel_tag(pixel_tag),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic coord_t clamp_q460(input wide_t v);
        if (v[PROD_W+1:COORD_W-1] == '0 || v[PROD_W+1:COORD_W-1] == '1)
            return v[COORD_W-1:0];
        return v[PROD_W+1] ? Q_MIN : Q_MAX;
    endfunction

    // iterations of z = z*z + c before |z|^2 reaches 4, capped at the limit
    function automatic logic [COUNT_W-1:0] escape_iterations(input logic [PIX_W-1:0] pix);
        int unsigned col, row, n;
        wide_t       col_w, row_w, base_w, step_w, cre_w, cim_w;
        wide_t       zr_w, zi_w, r2, i2, sq_sum, ri;
        coord_t      c_re, c_im, z_re, z_im;
        col = pix % PIXEL_COLUMNS;
        row = pix / PIXEL_COLUMNS;
        col_w = wide_t'(col);
        row_w = wide_t'(row);
        base_w = wide_t'(origin_re_q);
        step_w = wide_t'(step_re_q);
        c_re = clamp_q460(base_w + col_w * step_w);
        base_w = wide_t'(origin_im_q);
        step_w = wide_t'(step_im_q);
        c_im = clamp_q460(base_w + row_w * step_w);
        cre_w = wide_t'(c_re);
        cim_w = wide_t'(c_im);
        z_re = c_re;
        z_im = c_im;
        for (n = 0; n < iter_limit_q; n++) begin
            zr_w = wide_t'(z_re);
            zi_w = wide_t'(z_im);
            r2 = zr_w * zr_w;
            i2 = zi_w * zi_w;
            sq_sum = r2 + i2;
            if (sq_sum[PROD_W+1:ESCAPE_BIT] != '0)
                break;
            ri = zr_w * zi_w;
            z_re = clamp_q460(cre_w + ((r2 - i2) >>> FRAC_W));
            z_im = clamp_q460(cim_w + (ri >>> (FRAC_W - 1)));
        end
        return n[COUNT_W-1:0];
    endfunction

    function automatic int next_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return PIX_W'($urandom_range(0, PIXEL_LAST));
        if (r < 94)
            return PIX_W'($urandom_range(PIXEL_LAST + 1, PIX_ALL));
        return PIX_W'($urandom_range(0, PIXEL_LAST / PIXEL_COLUMNS) * PIXEL_COLUMNS
                      + ($urandom_range(0, 1) ? PIXEL_COLUMNS - 1 : 0));
    endfunction

    task automatic note_mismatch(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endtask

    // all tasks below start and end on a falling edge
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int            gap;
        pixel_result_t want;
        gap = next_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_index <= pix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want.count = escape_iterations(pix);
        want.tag = pix;
        pending_results.push_back(want);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        case (addr)
            CFG_ORIGIN_RE:       origin_re_q = data;
            CFG_ORIGIN_IM:       origin_im_q = data;
            CFG_STEP_RE:         step_re_q = data[STEP_W-1:0];
            CFG_STEP_IM:         step_im_q = data[STEP_W-1:0];
            CFG_ITERATION_LIMIT: iter_limit_q = data[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_view(input logic [63:0] ore, input logic [63:0] oim,
                            input logic [63:0] sre, input logic [63:0] sim,
                            input logic [63:0] lim);
        cfg_write(CFG_ORIGIN_RE, ore);
        cfg_write(CFG_ORIGIN_IM, oim);
        cfg_write(CFG_STEP_RE, sre);
        cfg_write(CFG_STEP_IM, sim);
        cfg_write(CFG_ITERATION_LIMIT, lim);
    endtask

    task automatic test_default_view();
        send_pixel('0);
        send_pixel(PIX_W'(PIXEL_LAST));
        send_pixel(PIX_CENTER);
        send_pixel(PIX_ALL);                // row past the bottom edge
        send_pixel(19'd120200);
    endtask

    task automatic test_limit_extremes();
        wait_drained();
        cfg_write(CFG_ITERATION_LIMIT, '0);
        send_pixel(PIX_CENTER);
        send_pixel('0);
        wait_drained();
        cfg_write(CFG_ITERATION_LIMIT, 64'd1);
        send_pixel(PIX_CENTER);
        send_pixel('0);
        wait_drained();
        cfg_write(CFG_ITERATION_LIMIT, CFG_DATA_W'({COUNT_W{1'b1}}));
        send_pixel(PIX_CENTER);             // never escapes, runs the full limit
        send_pixel(PIX_W'(PIXEL_LAST));
    endtask

    task automatic test_unknown_registers();
        int a;
        wait_drained();
        set_view(ORIGIN_RE_RESET, ORIGIN_IM_RESET, 64'(STEP_RE_RESET), 64'(STEP_IM_RESET),
                 64'd20);
        for (a = CFG_ITERATION_LIMIT + 1; a < 2 ** CFG_ADDR_W; a++)
            cfg_write(a[CFG_ADDR_W-1:0], rand64());
        send_pixel(PIX_CENTER);
        send_pixel(19'd120200);
        send_pixel(random_pixel());
    endtask

    task automatic test_saturation();
        wait_drained();
        // steps with bit 63 set to check that it is dropped
        set_view(Q_MAX, Q_MIN, '1, '1, 64'd8);
        send_pixel('0);
        send_pixel(PIX_W'(PIXEL_COLUMNS - 1));
        send_pixel(PIX_ALL);
        wait_drained();
        set_view(Q_MIN, '0, '0, '0, 64'd8);
        send_pixel(19'd12345);
        wait_drained();
        // |c|^2 exactly 4 counts as escaped
        set_view(-(Q_ONE * 2), '0, '0, '0, 64'd16);
        send_pixel(random_pixel());
        wait_drained();
        set_view(Q_ONE / 4, '0, '0, '0, 64'd16);
        send_pixel(random_pixel());
    endtask

    task automatic test_random_views();
        int          phase, k, kind;
        logic [63:0] lim;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            gaps_on = (phase % 4 != 3);
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                set_view(coord_t'(rand64() % Q_ONE) - (Q_ONE * 5) / 2,
                         coord_t'(rand64() % (Q_ONE / 2)) - (Q_ONE * 7) / 4,
                         (Q_ONE >> 10) + rand64() % (Q_ONE >> 7),
                         (Q_ONE >> 10) + rand64() % (Q_ONE >> 7),
                         64'($urandom_range(1, 40)));
            end else if (kind < 8) begin
                // zoom near the boundary
                set_view(coord_t'(rand64() % (Q_ONE >> 3)) - (Q_ONE * 3) / 4,
                         coord_t'(rand64() % (Q_ONE >> 3)) + (Q_ONE >> 3),
                         rand64() % (Q_ONE >> 14),
                         rand64() % (Q_ONE >> 14),
                         64'($urandom_range(1, 64)));
            end else begin
                lim = (rand64() & ~64'hFFF) | 64'($urandom_range(1, 1024));
                set_view(rand64(), rand64(), rand64(), rand64(), lim);
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // hold off until every request in flight has its result
                if ($urandom_range(0, 49) == 0 || (phase == 5 && k == 20))
                    wait_drained();
                send_pixel(random_pixel());
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_view();
        test_limit_extremes();
        test_unknown_registers();
        test_saturation();
        test_random_views();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // output stall: mostly short bursts, a few long ones
    always @(negedge clk) begin
        int  r;
        logic hold;
        hold = 1'b0;
        if (gaps_on && rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                hold = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r >= 70) begin
                    stall_left = (r >= 97) ? $urandom_range(20, 80) : $urandom_range(0, 3);
                    hold = 1'b1;
                end
            end
        end else begin
            stall_left = 0;
        end
        out_stall <= hold;
    end

    always @(posedge clk) begin
        pixel_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result: pixel_tag %0d escape_count %0d",
                                        pixel_tag, escape_count));
            end else begin
                want = pending_results.pop_front();
                if (pixel_tag !== want.tag || escape_count !== want.count)
                    note_mismatch($sformatf(
                        "mismatch: pixel_tag exp %0d got %0d, escape_count exp %0d got %0d",
                        want.tag, pixel_tag, want.count, escape_count));
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
